// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sdm_pkg.sv =====
package sdm_pkg;

    localparam int MAX_DISTINCT_DEF = 256;
    localparam int SAMPLE_BITS_DEF  = 32;

    localparam int COUNT_W  = 9;
    localparam int DCOUNT_W = 9;

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 9'd511;
    localparam logic [DCOUNT_W-1:0] DCOUNT_MAX = 9'd511;
    localparam logic [31:0]         EMPTY_MODE = 32'hD8F1_0000;

    localparam logic [1:0] CMD_ADD        = 2'd0;
    localparam logic [1:0] CMD_ADD_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH     = 2'd2;

    typedef struct packed {
        logic add;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic hit;
        logic sat;
    } t_cell_stat;

endpackage

// ===== hdl/sdm_cell.sv =====
module sdm_cell #(
    parameter int SAMPLE_BITS = sdm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sdm_pkg::t_cell_ctl               i_ctl,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  logic                             i_prev_used,
    input  logic                             i_any_hit,
    input  logic                             i_tok_valid,
    input  logic [sdm_pkg::COUNT_W-1:0]      i_tok_count,
    input  logic [SAMPLE_BITS-1:0]           i_tok_value,
    output logic                             o_used,
    output sdm_pkg::t_cell_stat              o_stat,
    output logic                             o_tok_valid,
    output logic [sdm_pkg::COUNT_W-1:0]      o_tok_count,
    output logic [SAMPLE_BITS-1:0]           o_tok_value
);

    logic                        r_used;
    logic [SAMPLE_BITS-1:0]      r_value;
    logic [sdm_pkg::COUNT_W-1:0] r_count;
    logic                        r_tok_valid;
    logic [sdm_pkg::COUNT_W-1:0] r_tok_count;
    logic [SAMPLE_BITS-1:0]      r_tok_value;

    logic w_hit;
    logic w_sat;
    logic w_claim;
    logic w_take;

    assign w_hit   = r_used && (r_value == i_sample);
    assign w_sat   = w_hit && (r_count == sdm_pkg::COUNT_MAX);
    assign w_claim = !r_used && i_prev_used && !i_any_hit;
    assign w_take  = r_used && ((r_count > i_tok_count) ||
                     ((r_count == i_tok_count) && ($signed(r_value) < $signed(i_tok_value))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
            if (i_ctl.clear) begin
                r_used <= 1'b0;
            end else if (i_ctl.add && w_claim) begin
                r_used <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.add && w_claim) begin
            r_value <= i_sample;
            r_count <= sdm_pkg::COUNT_W'(1);
        end else if (i_ctl.add && w_hit && !w_sat) begin
            r_count <= r_count + sdm_pkg::COUNT_W'(1);
        end
        if (i_tok_valid) begin
            r_tok_count <= w_take ? r_count : i_tok_count;
            r_tok_value <= w_take ? r_value : i_tok_value;
        end
    end

    assign o_used      = r_used;
    assign o_stat.hit  = w_hit;
    assign o_stat.sat  = w_sat;
    assign o_tok_valid = r_tok_valid;
    assign o_tok_count = r_tok_count;
    assign o_tok_value = r_tok_value;

endmodule

// ===== hdl/sample_diversity_and_mode.sv =====
// Channel | Direction | Handshake                 | Payload
// input   | in        | i_in_valid / o_in_stall   | i_cmd, i_sample_value
// output  | out       | o_out_valid / i_out_stall | o_distinct_count, o_mode_value,
//         |           |                           | o_mode_valid, o_overflow
//
// An add transaction is taken whenever input is not stalled; all cells compare the sample at once.
// A finish transaction stalls input while the mode token walks the cell chain one cell
// per cycle, and until the result is unloaded.
// Reset clears occupancy, the occupancy count and flags; stored values and per-cell counts need no reset.
// A result waiting under i_out_stall does not block new samples, only the next unload.
`include "assert_macros.svh"

module sample_diversity_and_mode #(
    parameter int MAX_DISTINCT = sdm_pkg::MAX_DISTINCT_DEF,
    parameter int SAMPLE_BITS  = sdm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_cmd,
    input  logic signed [31:0]               i_sample_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sdm_pkg::DCOUNT_W-1:0]     o_distinct_count,
    output logic signed [31:0]               o_mode_value,
    output logic                             o_mode_valid,
    output logic                             o_overflow
);

    localparam int UW = $clog2(MAX_DISTINCT + 1);
    localparam int WW = (UW > sdm_pkg::DCOUNT_W) ? UW : sdm_pkg::DCOUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic            r_seed;
    logic [UW-1:0]   r_used_cnt;
    logic            r_ovf;
    logic            r_out_valid;
    logic [sdm_pkg::DCOUNT_W-1:0] r_distinct;
    logic [31:0]     r_mode;
    logic            r_mode_valid;
    logic            r_out_ovf;

    logic                        w_in_acc;
    logic                        w_add;
    logic                        w_fin;
    logic                        w_load;
    logic [SAMPLE_BITS-1:0]      w_sample;
    sdm_pkg::t_cell_ctl          w_ctl;
    logic [MAX_DISTINCT-1:0]     w_used;
    logic [MAX_DISTINCT-1:0]     w_hit;
    logic [MAX_DISTINCT-1:0]     w_sat;
    logic                        w_any_hit;
    logic                        w_any_sat;
    logic                        w_full;
    logic [MAX_DISTINCT:0]       w_tok_valid;
    logic [sdm_pkg::COUNT_W-1:0] w_tok_count [MAX_DISTINCT+1];
    logic [SAMPLE_BITS-1:0]      w_tok_value [MAX_DISTINCT+1];
    logic [WW-1:0]               w_used_ext;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_add      = w_in_acc &&
                        ((i_cmd == sdm_pkg::CMD_ADD) || (i_cmd == sdm_pkg::CMD_ADD_FINISH));
    assign w_fin      = w_in_acc &&
                        ((i_cmd == sdm_pkg::CMD_ADD_FINISH) || (i_cmd == sdm_pkg::CMD_FINISH));
    assign w_load     = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign w_sample   = SAMPLE_BITS'(i_sample_value);

    assign w_ctl.add   = w_add;
    assign w_ctl.clear = w_load;

    assign w_tok_valid[0] = r_seed;
    assign w_tok_count[0] = '0;
    assign w_tok_value[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_DISTINCT; g++) begin : g_cell
            sdm_pkg::t_cell_stat w_stat;
            logic                w_prev;
            if (g == 0) begin : g_first
                assign w_prev = 1'b1;
            end else begin : g_rest
                assign w_prev = w_used[g-1];
            end
            sdm_cell #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_sample    (w_sample),
                .i_prev_used (w_prev),
                .i_any_hit   (w_any_hit),
                .i_tok_valid (w_tok_valid[g]),
                .i_tok_count (w_tok_count[g]),
                .i_tok_value (w_tok_value[g]),
                .o_used      (w_used[g]),
                .o_stat      (w_stat),
                .o_tok_valid (w_tok_valid[g+1]),
                .o_tok_count (w_tok_count[g+1]),
                .o_tok_value (w_tok_value[g+1])
            );
            assign w_hit[g] = w_stat.hit;
            assign w_sat[g] = w_stat.sat;
        end
    endgenerate

    assign w_any_hit  = |w_hit;
    assign w_any_sat  = |w_sat;
    assign w_full     = w_used[MAX_DISTINCT-1];
    assign w_used_ext = WW'(r_used_cnt);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_fin) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tok_valid[MAX_DISTINCT]) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= 1'b0;
            r_used_cnt  <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seed  <= w_fin;
            if (w_load) begin
                r_used_cnt <= '0;
                r_ovf      <= 1'b0;
            end else if (w_add) begin
                if (!w_any_hit && !w_full) begin
                    r_used_cnt <= r_used_cnt + UW'(1);
                end
                if ((!w_any_hit && w_full) || w_any_sat) begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_distinct   <= (w_used_ext > WW'(sdm_pkg::DCOUNT_MAX)) ?
                            sdm_pkg::DCOUNT_MAX : w_used_ext[sdm_pkg::DCOUNT_W-1:0];
            r_mode       <= (r_used_cnt == '0) ?
                            sdm_pkg::EMPTY_MODE : 32'(w_tok_value[MAX_DISTINCT]);
            r_mode_valid <= (r_used_cnt != '0);
            r_out_ovf    <= r_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_distinct_count = r_distinct;
    assign o_mode_value     = $signed(r_mode);
    assign o_mode_valid     = r_mode_valid;
    assign o_overflow       = r_out_ovf;

    `SDM_ASSERT_NOW(a_used_count, 1'b1, ($countones(w_used) == r_used_cnt), "occupancy count mismatch")
    `SDM_ASSERT_NOW(a_single_hit, 1'b1, $onehot0(w_hit), "sample matched more than one cell")
    `SDM_ASSERT_NOW(a_tok_in_scan, w_tok_valid[MAX_DISTINCT], (r_state == ST_SCAN), "token out of scan")
    `SDM_ASSERT_NEXT(a_load_clears, w_load, ((r_used_cnt == '0) && !r_ovf && (w_used == '0)), "set not cleared")

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXD = sdm_pkg::MAX_DISTINCT_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_LEN = 1500;
    localparam int TAIL = MAXD + 8;
    localparam int STUCK_LIMIT = 10000;

    typedef struct packed {
        logic [sdm_pkg::DCOUNT_W-1:0] dcount;
        logic [31:0]                  mode;
        logic                         mode_valid;
        logic                         overflow;
    } t_set_summary;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [1:0]                   in_cmd = sdm_pkg::CMD_ADD;
    logic signed [31:0]           in_sample = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [sdm_pkg::DCOUNT_W-1:0] out_dcount;
    logic signed [31:0]           out_mode;
    logic                         out_mode_valid;
    logic                         out_overflow;

    logic [31:0]                  tbl_value [MAXD];
    logic [sdm_pkg::COUNT_W-1:0]  tbl_count [MAXD];
    int unsigned                  tbl_used = 0;
    bit                           tbl_ovf = 1'b0;

    t_set_summary        pending_summaries[$];
    int                  errors = 0;
    int                  sets_checked = 0;
    int                  samples_sent = 0;
    int                  in_idle_pct = 0;
    int                  out_stall_pct = 0;
    int                  holdoff_req = 0;
    int                  holdoff_ack = 0;
    int                  holdoff_left = 0;
    int                  stuck = 0;

    sample_diversity_and_mode u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (in_cmd),
        .i_sample_value   (in_sample),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_distinct_count (out_dcount),
        .o_mode_value     (out_mode),
        .o_mode_valid     (out_mode_valid),
        .o_overflow       (out_overflow)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void tally_sample(logic [31:0] v);
        int hit;
        hit = -1;
        for (int k = 0; k < tbl_used; k++) begin
            if (tbl_value[k] == v) begin
                hit = k;
                break;
            end
        end
        if (hit >= 0) begin
            if (tbl_count[hit] == sdm_pkg::COUNT_MAX) begin
                tbl_ovf = 1'b1;
            end else begin
                tbl_count[hit] = tbl_count[hit] + sdm_pkg::COUNT_W'(1);
            end
        end else if (tbl_used < MAXD) begin
            tbl_value[tbl_used] = v;
            tbl_count[tbl_used] = sdm_pkg::COUNT_W'(1);
            tbl_used++;
        end else begin
            tbl_ovf = 1'b1;
        end
    endfunction

    function automatic t_set_summary close_set();
        t_set_summary                s;
        logic [sdm_pkg::COUNT_W-1:0] best_cnt;
        logic signed [31:0]          best_val;
        best_cnt = '0;
        best_val = '0;
        for (int k = 0; k < tbl_used; k++) begin
            if (tbl_count[k] > best_cnt ||
                (tbl_count[k] == best_cnt && $signed(tbl_value[k]) < best_val)) begin
                best_cnt = tbl_count[k];
                best_val = tbl_value[k];
            end
        end
        s.dcount = (tbl_used > sdm_pkg::DCOUNT_MAX) ?
                   sdm_pkg::DCOUNT_MAX : tbl_used[sdm_pkg::DCOUNT_W-1:0];
        s.mode = (tbl_used == 0) ? sdm_pkg::EMPTY_MODE : best_val;
        s.mode_valid = (tbl_used != 0);
        s.overflow = tbl_ovf;
        tbl_used = 0;
        tbl_ovf = 1'b0;
        return s;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_summary();
        t_set_summary want;
        if (pending_summaries.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: count %0d mode %h",
                                      out_dcount, out_mode));
        end else begin
            want = pending_summaries.pop_front();
            sets_checked++;
            if (out_dcount !== want.dcount)
                report_mismatch($sformatf("set %0d distinct_count got %0d expected %0d",
                                          sets_checked, out_dcount, want.dcount));
            if (out_mode !== want.mode)
                report_mismatch($sformatf("set %0d mode_value got %h expected %h",
                                          sets_checked, out_mode, want.mode));
            if (out_mode_valid !== want.mode_valid)
                report_mismatch($sformatf("set %0d mode_valid got %b expected %b",
                                          sets_checked, out_mode_valid, want.mode_valid));
            if (out_overflow !== want.overflow)
                report_mismatch($sformatf("set %0d overflow got %b expected %b",
                                          sets_checked, out_overflow, want.overflow));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            check_summary();
        end
    end

    always @(posedge clk) begin
        if (holdoff_req != holdoff_ack) begin
            holdoff_ack <= holdoff_req;
            holdoff_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) ||
                (out_valid && !out_stall && pending_summaries.size() != 0)) begin
                stuck <= 0;
            end else begin
                stuck <= stuck + 1;
            end
            if (stuck >= STUCK_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", stuck);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] c, logic [31:0] v);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd <= c;
        in_sample <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        unique case (c)
            sdm_pkg::CMD_ADD: begin
                tally_sample(v);
                samples_sent++;
            end
            sdm_pkg::CMD_ADD_FINISH: begin
                tally_sample(v);
                samples_sent++;
                pending_summaries.push_back(close_set());
            end
            sdm_pkg::CMD_FINISH: pending_summaries.push_back(close_set());
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_summaries.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(sdm_pkg::CMD_FINISH, 32'h1234_5678);
        send_item(sdm_pkg::CMD_ADD_FINISH, 32'h7FFF_FFFF);
        send_item(sdm_pkg::CMD_ADD, 32'h8000_0000);
        send_item(sdm_pkg::CMD_ADD, 32'h7FFF_FFFF);
        send_item(sdm_pkg::CMD_ADD_FINISH, 32'h8000_0000);
        send_item(sdm_pkg::CMD_ADD, 32'h0000_0001);
        send_item(sdm_pkg::CMD_ADD, 32'hFFFF_FFFF);
        send_item(sdm_pkg::CMD_ADD, 32'h0000_0001);
        send_item(sdm_pkg::CMD_ADD_FINISH, 32'hFFFF_FFFF);
        send_item(sdm_pkg::CMD_ADD, 32'h0000_0007);
        send_item(CMD_UNUSED, 32'h0000_0005);
        send_item(CMD_UNUSED, 32'h0000_0005);
        send_item(sdm_pkg::CMD_ADD_FINISH, 32'h0000_0009);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF);
        send_item(sdm_pkg::CMD_FINISH, 32'h0000_0000);
        send_item(sdm_pkg::CMD_ADD, 32'h5555_5555);
        send_item(sdm_pkg::CMD_ADD, 32'hAAAA_AAAA);
        send_item(sdm_pkg::CMD_FINISH, 32'hFFFF_FFFF);
        send_item(sdm_pkg::CMD_ADD, 32'h0000_0000);
        send_item(sdm_pkg::CMD_ADD_FINISH, sdm_pkg::EMPTY_MODE);
        wait_drained();
    endtask

    task automatic test_table_full();
        for (int k = 0; k < MAXD; k++)
            send_item(sdm_pkg::CMD_ADD, (k * 32'h0101_0101) ^ 32'h5A5A_0000);
        send_item(sdm_pkg::CMD_FINISH, 32'h0);
        for (int k = 0; k < MAXD; k++)
            send_item(sdm_pkg::CMD_ADD, (k * 32'h0101_0101) ^ 32'h5A5A_0000);
        for (int k = 0; k < 5; k++) send_item(sdm_pkg::CMD_ADD, 32'h1234_5677);
        send_item(sdm_pkg::CMD_ADD, (100 * 32'h0101_0101) ^ 32'h5A5A_0000);
        send_item(sdm_pkg::CMD_ADD_FINISH, (100 * 32'h0101_0101) ^ 32'h5A5A_0000);
        send_item(sdm_pkg::CMD_ADD_FINISH, 32'h1234_5677);
        wait_drained();
    endtask

    task automatic test_count_saturation();
        for (int k = 0; k < sdm_pkg::COUNT_MAX; k++)
            send_item(sdm_pkg::CMD_ADD, sdm_pkg::EMPTY_MODE);
        send_item(sdm_pkg::CMD_ADD, 32'h8000_0000);
        send_item(sdm_pkg::CMD_ADD_FINISH, sdm_pkg::EMPTY_MODE);
        wait_drained();
    endtask

    task automatic test_backpressure();
        in_idle_pct = 0;
        out_stall_pct = 0;
        holdoff_req <= holdoff_req + 1;
        for (int s = 0; s < 8; s++) begin
            send_item(sdm_pkg::CMD_ADD, $urandom());
            send_item(sdm_pkg::CMD_ADD, $urandom_range(3));
            send_item(sdm_pkg::CMD_ADD_FINISH, $urandom_range(3));
        end
        wait_drained();
    endtask

    function automatic logic [31:0] pick_value();
        unique case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(20) - 10;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_sets(int target);
        logic [31:0] pool [8];
        int          pool_n;
        int          len;
        int          sent;
        logic [31:0] v;
        sent = 0;
        while (sent < target) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(10);
            pool_n = $urandom_range(1, 8);
            for (int k = 0; k < pool_n; k++) pool[k] = pick_value();
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(29) == 0) send_item(CMD_UNUSED, $urandom());
                v = pool[$urandom_range(pool_n - 1)];
                if (j == len - 1 && $urandom_range(1) == 0) begin
                    send_item(sdm_pkg::CMD_ADD_FINISH, v);
                end else begin
                    send_item(sdm_pkg::CMD_ADD, v);
                end
                sent++;
            end
            if (len == 0 || in_cmd != sdm_pkg::CMD_ADD_FINISH) begin
                send_item(sdm_pkg::CMD_FINISH, $urandom());
                sent++;
            end
        end
    endtask

    task automatic test_random();
        int idle_tab  [4] = '{0, 60, 0, 11};
        int stall_tab [4] = '{0, 0, 60, 11};
        for (int p = 0; p < 4; p++) begin
            in_idle_pct = idle_tab[p];
            out_stall_pct = stall_tab[p];
            random_sets(130);
        end
        in_idle_pct = 0;
        out_stall_pct = 0;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_count_saturation();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (TAIL) @(posedge clk);
        $display("Covered %0d sets from %0d samples: empty sets, ties, extremes, ignored",
                 sets_checked, samples_sent);
        $display("commands, full table, saturated counts, long output hold-off, idle phases.");
        if (errors == 0 && pending_summaries.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sample_diversity_and_mode.f =====
+incdir+hdl
hdl/sdm_pkg.sv
hdl/sdm_cell.sv
hdl/sample_diversity_and_mode.sv
dv/tb.sv
